// ----- rtl/kfp_pkg.sv -----
// ----------------------------------------------------------------------------
// kfp_pkg
// Shared types and character codes for the keypad frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package kfp_pkg;

  // frame characters
  localparam logic [7:0] ChLt      = 8'h3C;  // '<'
  localparam logic [7:0] ChK       = 8'h4B;  // 'K'
  localparam logic [7:0] ChP       = 8'h50;  // 'P'
  localparam logic [7:0] ChColon   = 8'h3A;  // ':'
  localparam logic [7:0] ChEq      = 8'h3D;  // '='
  localparam logic [7:0] ChGt      = 8'h3E;  // '>'
  localparam logic [7:0] ChNl      = 8'h0A;  // newline
  localparam logic [7:0] ChOne     = 8'h31;  // '1'
  localparam logic [7:0] ChTwo     = 8'h32;  // '2'
  localparam logic [7:0] ChEight   = 8'h38;  // '8'
  localparam logic [7:0] ChZero    = 8'h30;  // '0'

  // whitespace skipped before a line starts
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChVtab    = 8'h0B;
  localparam logic [7:0] ChFf      = 8'h0C;
  localparam logic [7:0] ChCr      = 8'h0D;

  localparam int unsigned FrameLen = 9;

  // input kinds
  localparam logic KindByte = 1'b0;
  localparam logic KindPop  = 1'b1;

  // result kinds
  localparam logic ResLine  = 1'b0;
  localparam logic ResPop   = 1'b1;

  // packed key event: bit 4 module-1, bits 3:1 key-1, bit 0 value
  typedef logic [4:0] event_t;

  // line status from the parser
  typedef struct packed {
    logic   line_end;  // newline closing a nonempty line
    logic   ok;        // frame complete and matched
    event_t ev;        // decoded event
  } line_status_t;

  // result held between the state update and the output register
  typedef struct packed {
    logic       result_kind;
    logic       frame_ok;
    logic       got_event;
    logic       has_ev;
    logic       from_mem;   // event comes from the fifo read port
    event_t     ev;
    logic [4:0] fill;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/kfp_line_parser.sv -----
// ----------------------------------------------------------------------------
// kfp_line_parser
// Positional frame matcher for one received line.
// ----------------------------------------------------------------------------
`default_nettype none

module kfp_line_parser
  import kfp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         take,      // byte transfer accepted
  input  wire logic [7:0]   rx_byte,
  output line_status_t      status
);

  logic [3:0] char_pos;
  logic       line_started;
  logic       frame_good;
  event_t     captured_event;

  logic       is_nl;
  logic       is_blank;
  logic       match;
  event_t     ev_bits;
  logic [7:0] key_off;

  // character classes
  always_comb begin
    is_nl    = (rx_byte == ChNl);
    is_blank = (rx_byte inside {ChSpace, ChTab, ChVtab, ChFf, ChCr});
    key_off  = rx_byte - ChOne;
  end

  // expected character at the current position
  always_comb begin
    match   = 1'b1;
    ev_bits = '0;
    case (char_pos)
      4'd0: match = (rx_byte == ChLt);
      4'd1: match = (rx_byte == ChK);
      4'd2: match = (rx_byte == ChP);
      4'd3: begin
        match      = (rx_byte inside {[ChOne:ChTwo]});
        ev_bits[4] = match & (rx_byte == ChTwo);
      end
      4'd4: match = (rx_byte == ChColon);
      4'd5: begin
        match        = (rx_byte inside {[ChOne:ChEight]});
        ev_bits[3:1] = match ? key_off[2:0] : 3'd0;
      end
      4'd6: match = (rx_byte == ChEq);
      4'd7: begin
        match      = (rx_byte == ChZero) || (rx_byte == ChOne);
        ev_bits[0] = match & (rx_byte == ChOne);
      end
      4'd8: match = (rx_byte == ChGt);
      default: match = 1'b1;
    endcase
  end

  // status seen by the newline
  always_comb begin
    status.line_end = take & is_nl & line_started;
    status.ok       = frame_good & (char_pos >= 4'(FrameLen));
    status.ev       = captured_event;
  end

  // line state
  always_ff @(posedge clk) begin
    if (rst) begin
      char_pos       <= '0;
      line_started   <= 1'b0;
      frame_good     <= 1'b1;
      captured_event <= '0;
    end else if (take) begin
      if (is_nl) begin
        if (line_started) begin
          char_pos       <= '0;
          line_started   <= 1'b0;
          frame_good     <= 1'b1;
          captured_event <= '0;
        end
      end else if (line_started || !is_blank) begin
        line_started <= 1'b1;
        if (char_pos < 4'(FrameLen)) begin
          char_pos       <= char_pos + 4'd1;
          frame_good     <= frame_good & match;
          captured_event <= captured_event | ev_bits;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/kfp_event_fifo.sv -----
// ----------------------------------------------------------------------------
// kfp_event_fifo
// Ring buffer of key events; a push when full drops the oldest entry.
// ----------------------------------------------------------------------------
`default_nettype none

module kfp_event_fifo
  import kfp_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 16
)(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  event_t      push_ev,
  input  wire logic   pop,        // pop request, ignored when empty
  output logic        empty,
  output logic [4:0]  fill_next,  // fill level after this transfer
  output event_t      rd_data     // registered read of the popped entry
);

  localparam int unsigned PW = $clog2(FIFO_DEPTH);
  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);
  localparam logic [PW-1:0] LastIdx = PW'(FIFO_DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(FIFO_DEPTH);

  event_t        mem [FIFO_DEPTH];
  logic [PW-1:0] write_ptr;
  logic [PW-1:0] read_ptr;
  logic [CW-1:0] event_count;
  logic [CW-1:0] event_count_next;
  logic          full;
  logic          pop_en;
  logic [PW-1:0] wr_inc;
  logic [PW-1:0] rd_inc;

  // flags and wrapped increments
  always_comb begin
    empty  = (event_count == '0);
    full   = (event_count == FullCnt);
    pop_en = pop & !empty;
    wr_inc = (write_ptr == LastIdx) ? '0 : write_ptr + 1'b1;
    rd_inc = (read_ptr == LastIdx) ? '0 : read_ptr + 1'b1;
  end

  // fill after this transfer
  always_comb begin
    event_count_next = event_count;
    if (push && !full) begin
      event_count_next = event_count + 1'b1;
    end else if (pop_en) begin
      event_count_next = event_count - 1'b1;
    end
    fill_next = 5'(event_count_next);
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      write_ptr   <= '0;
      read_ptr    <= '0;
      event_count <= '0;
    end else begin
      event_count <= event_count_next;
      if (push) begin
        write_ptr <= wr_inc;
        if (full) begin
          read_ptr <= rd_inc;
        end
      end else if (pop_en) begin
        read_ptr <= rd_inc;
      end
    end
  end

  // storage, one write and one registered read port
  always_ff @(posedge clk) begin
    if (push) begin
      mem[write_ptr] <= push_ev;
    end
    if (pop_en) begin
      rd_data <= mem[read_ptr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/keypad_frame_parser_fifo.sv -----
// ----------------------------------------------------------------------------
// keypad_frame_parser_fifo
// Keypad frame parser with a key event fifo, stream in and stream out.
// ----------------------------------------------------------------------------
// One transfer is taken every clock cycle unless a stall on the master side
// has filled the holding stage. A byte transfer updates the line matcher; a
// newline closing a nonempty line gives a status result and, for a valid
// <KPm:k=v> frame, pushes the event. A pop transfer always gives an answer. A
// result is registered in the holding stage, with the fifo's registered read,
// then in the output register. Stalls on the master side fill a one-entry
// holding stage before the slave side stops. No clearing pass after reset.
`default_nettype none

module keypad_frame_parser_fifo
  import kfp_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 16
)(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  wire logic [0:0]  s_tuser,   // [0] kind
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [0] frame_ok, [1] got_event, [3:2] module_num,
                                      // [7:4] key_num, [8] key_value, [13:9] fill_level
  output logic [0:0]       m_tuser    // [0] result_kind
);

  logic         acc;
  logic         is_pop;
  logic         byte_take;
  line_status_t line;
  logic         push;
  logic         fifo_empty;
  logic [4:0]   fill_next;
  event_t       rd_data;

  result_t      hold;
  logic         hold_valid;
  result_t      hold_next;
  logic         hold_load;
  logic         advance;
  event_t       out_ev;

  // input handshake
  always_comb begin
    advance   = hold_valid & (!m_tvalid | m_tready);
    s_tready  = !hold_valid | advance;
    acc       = s_tvalid & s_tready;
    is_pop    = (s_tuser[0] == KindPop);
    byte_take = acc & !is_pop;
    push      = line.line_end & line.ok;
  end

  kfp_line_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .take    (byte_take),
    .rx_byte (s_tdata),
    .status  (line)
  );

  kfp_event_fifo #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_ev   (line.ev),
    .pop       (acc & is_pop),
    .empty     (fifo_empty),
    .fill_next (fill_next),
    .rd_data   (rd_data)
  );

  // result of the accepted transfer
  always_comb begin
    hold_load             = (acc & is_pop) | line.line_end;
    hold_next.result_kind = is_pop ? ResPop : ResLine;
    hold_next.frame_ok    = !is_pop & line.ok;
    hold_next.got_event   = is_pop & !fifo_empty;
    hold_next.has_ev      = is_pop ? !fifo_empty : line.ok;
    hold_next.from_mem    = is_pop;
    hold_next.ev          = line.ev;
    hold_next.fill        = fill_next;
  end

  // holding stage
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= hold_load | (hold_valid & !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (hold_load) begin
      hold <= hold_next;
    end
  end

  // output register with event decode
  always_comb begin
    out_ev = hold.from_mem ? rd_data : hold.ev;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= advance | (m_tvalid & !m_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tuser[0]     <= hold.result_kind;
      m_tdata[0]     <= hold.frame_ok;
      m_tdata[1]     <= hold.got_event;
      m_tdata[3:2]   <= hold.has_ev ? {1'b0, out_ev[4]} + 2'd1 : 2'd0;
      m_tdata[7:4]   <= hold.has_ev ? {1'b0, out_ev[3:1]} + 4'd1 : 4'd0;
      m_tdata[8]     <= hold.has_ev & out_ev[0];
      m_tdata[13:9]  <= hold.fill;
      m_tdata[15:14] <= 2'b00;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/kfp_checker.sv -----
// ----------------------------------------------------------------------------
// kfp_checker
// Port-level checks for the keypad frame parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module kfp_checker
  import kfp_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata,
  input wire logic [0:0]  m_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // with no result pending the slave side is open
  a_ready_when_idle: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with output empty");

  // an accepted frame carries an event and leaves the fifo nonempty
  a_ok_has_event: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] == ResLine && m_tdata[0]
      |-> m_tdata[3:2] != 2'd0 && m_tdata[7:4] != 4'd0 && m_tdata[13:9] != 5'd0)
    else $error("valid frame without event");

  // an empty pop carries no event
  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] == ResPop && !m_tdata[1]
      |-> m_tdata[8:2] == 7'd0 && !m_tdata[0])
    else $error("empty pop carries event fields");

endmodule

bind keypad_frame_parser_fifo kfp_checker u_kfp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
